@@ rtl/rsag_pkg.sv @@
`default_nettype none

package rsag_pkg;

    localparam int MAX_SPAN    = 64;
    localparam int PIXEL_BYTES = 2;

    localparam int LEN_W = 7;
    localparam int PB_W  = $clog2(PIXEL_BYTES) + 2;

    localparam logic [LEN_W-1:0]       MAX_SPAN_V    = LEN_W'(MAX_SPAN);
    localparam logic signed [PB_W-1:0] PIXEL_BYTES_S = PB_W'(PIXEL_BYTES);

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_CLIP_LEFT     = 3'd2,
        REG_CLIP_RIGHT    = 3'd3,
        REG_CLIP_TOP      = 3'd4,
        REG_CLIP_BOTTOM   = 3'd5,
        REG_SOURCE_STRIDE = 3'd6,
        REG_DEST_STRIDE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_bottom;
        logic [15:0]        source_stride;
        logic [15:0]        dest_stride;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [LEN_W-1:0]   idx;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [15:0] src_x0;
        logic signed [15:0] src_y0;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
    } t_pix;

endpackage

`default_nettype wire

@@ rtl/rsag_walker.sv @@
`default_nettype none

module rsag_walker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rsag_pkg::t_cfg              i_cfg,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic signed [15:0]          i_row_offset,
    input  wire logic signed [15:0]          i_column_offset,
    input  wire logic signed [15:0]          i_src_start_x,
    input  wire logic signed [15:0]          i_src_start_y,
    input  wire logic signed [31:0]          i_step_x,
    input  wire logic signed [31:0]          i_step_y,
    input  wire logic [rsag_pkg::LEN_W-1:0]  i_span_length,
    output rsag_pkg::t_pix                   o_pix
);
    import rsag_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BOUND = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic signed [16:0] r_y, r_x;
    logic [LEN_W-1:0]   r_len;
    logic signed [15:0] r_sx0, r_sy0;
    logic signed [31:0] r_stx, r_sty;
    logic [LEN_W-1:0]   r_i, r_end;

    logic signed [17:0] left_gap, room, first_c, hi_c, len_s;
    logic               row_ok, nonempty, last_c;

    always_comb begin
        left_gap = {{2{i_cfg.clip_left[15]}}, i_cfg.clip_left} - {r_x[16], r_x};
        room     = {{2{i_cfg.clip_right[15]}}, i_cfg.clip_right} - {r_x[16], r_x} + 18'sd1;
        len_s    = $signed({{(18-LEN_W){1'b0}}, r_len});
        first_c  = (left_gap > 18'sd0) ? left_gap : 18'sd0;
        hi_c     = (room < len_s) ? room : len_s;
        row_ok   = (r_y >= $signed({i_cfg.clip_top[15], i_cfg.clip_top}))
                && (r_y <= $signed({i_cfg.clip_bottom[15], i_cfg.clip_bottom}));
        nonempty = row_ok && (first_c < hi_c);
        last_c   = ((r_i + LEN_W'(1)) == r_end);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_BOUND;
                end
            end
            ST_BOUND: begin
                n_state = nonempty ? ST_RUN : ST_IDLE;
            end
            ST_RUN: begin
                if (last_c) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_y   <= {i_cfg.origin_y[15], i_cfg.origin_y} + {i_row_offset[15], i_row_offset};
            r_x   <= {i_cfg.origin_x[15], i_cfg.origin_x}
                   + {i_column_offset[15], i_column_offset};
            r_len <= (i_span_length > MAX_SPAN_V) ? MAX_SPAN_V : i_span_length;
            r_sx0 <= i_src_start_x;
            r_sy0 <= i_src_start_y;
            r_stx <= i_step_x;
            r_sty <= i_step_y;
        end
        if (r_state == ST_BOUND) begin
            r_i   <= first_c[LEN_W-1:0];
            r_end <= hi_c[LEN_W-1:0];
        end else if (r_state == ST_RUN) begin
            r_i <= r_i + LEN_W'(1);
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_pix.valid  = (r_state == ST_RUN);
        o_pix.last   = last_c;
        o_pix.idx    = r_i;
        o_pix.x      = r_x;
        o_pix.y      = r_y;
        o_pix.src_x0 = r_sx0;
        o_pix.src_y0 = r_sy0;
        o_pix.step_x = r_stx;
        o_pix.step_y = r_sty;
    end

endmodule

`default_nettype wire

@@ rtl/rsag_pipe.sv @@
`default_nettype none

module rsag_pipe (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [15:0]        i_source_stride,
    input  wire logic [15:0]        i_dest_stride,
    input  wire rsag_pkg::t_pix     i_pix,
    output logic                    o_valid,
    output logic signed [47:0]      o_source_offset,
    output logic signed [47:0]      o_dest_offset,
    output logic                    o_last_pixel
);
    import rsag_pkg::*;

    // Stage 1: fractional source products and destination column.
    logic               r_v1, r_l1;
    logic signed [39:0] r_px1, r_py1;
    logic signed [15:0] r_sx01, r_sy01;
    logic signed [16:0] r_y1;
    logic signed [17:0] r_dx1;

    // Stage 2: integer source coordinates.
    logic               r_v2, r_l2;
    logic signed [24:0] r_sx2, r_sy2;
    logic signed [16:0] r_y2;
    logic signed [17:0] r_dx2;

    // Stage 3: row and column byte terms.
    logic                       r_v3, r_l3;
    logic signed [41:0]         r_soy3;
    logic signed [24+PB_W:0]    r_sox3;
    logic signed [33:0]         r_doy3;
    logic signed [17+PB_W:0]    r_dox3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_pix.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1   <= i_pix.last;
        r_px1  <= i_pix.step_x * $signed({1'b0, i_pix.idx});
        r_py1  <= i_pix.step_y * $signed({1'b0, i_pix.idx});
        r_sx01 <= i_pix.src_x0;
        r_sy01 <= i_pix.src_y0;
        r_y1   <= i_pix.y;
        r_dx1  <= {i_pix.x[16], i_pix.x} + $signed({{(18-LEN_W){1'b0}}, i_pix.idx});

        r_l2  <= r_l1;
        r_sx2 <= {{9{r_sx01[15]}}, r_sx01} + {r_px1[39], r_px1[39:16]};
        r_sy2 <= {{9{r_sy01[15]}}, r_sy01} + {r_py1[39], r_py1[39:16]};
        r_y2  <= r_y1;
        r_dx2 <= r_dx1;

        r_l3   <= r_l2;
        r_soy3 <= r_sy2 * $signed({1'b0, i_source_stride});
        r_sox3 <= r_sx2 * PIXEL_BYTES_S;
        r_doy3 <= r_y2 * $signed({1'b0, i_dest_stride});
        r_dox3 <= r_dx2 * PIXEL_BYTES_S;

        o_last_pixel    <= r_l3;
        o_source_offset <= 48'(r_soy3) + 48'(r_sox3);
        o_dest_offset   <= 48'(r_doy3) + 48'(r_dox3);
    end

endmodule

`default_nettype wire

@@ rtl/rotated_span_address_generator_core.sv @@
`default_nettype none

// Rotated sprite span address generator.
// Each beat on the command channel (i_start while o_busy is low) carries one
// precomputed scanline descriptor. The block clips the span against the clip
// rectangle and emits one source and destination byte offset pair per
// surviving pixel, left to right, with o_last_pixel on the final one.
// Results appear on the output ports for one cycle each, marked by o_valid;
// the receiver cannot stall them.
// Registers are written via i_cfg_we, i_cfg_index and i_cfg_data and take
// effect at once; the user must write them only while the block is idle,
// which the block does not enforce. After a descriptor is accepted, the
// walker evaluates the clip bounds in its bound state, then issues one pixel
// per cycle into a four-stage address pipeline. o_busy stays high through
// the bound state and while pixels are issued (only the bound state for a
// clipped-away span). A new descriptor may be accepted while the last pixels
// of the previous one are still in the pipeline.
// Synchronous reset clears the registers to the full clip rectangle, zero
// origin and zero strides, and empties the pipeline.

module rotated_span_address_generator_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic                        i_cfg_we,
    input  wire logic [2:0]                  i_cfg_index,
    input  wire logic [15:0]                 i_cfg_data,
    input  wire logic signed [15:0]          i_row_offset,
    input  wire logic signed [15:0]          i_column_offset,
    input  wire logic signed [15:0]          i_src_start_x,
    input  wire logic signed [15:0]          i_src_start_y,
    input  wire logic signed [31:0]          i_step_x,
    input  wire logic signed [31:0]          i_step_y,
    input  wire logic [rsag_pkg::LEN_W-1:0]  i_span_length,
    output logic                             o_valid,
    output logic signed [47:0]               o_source_offset,
    output logic signed [47:0]               o_dest_offset,
    output logic                             o_last_pixel
);
    import rsag_pkg::*;

    t_cfg r_cfg;
    t_pix pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= 16'sh0000;
            r_cfg.origin_y      <= 16'sh0000;
            r_cfg.clip_left     <= 16'sh8000;
            r_cfg.clip_right    <= 16'sh7FFF;
            r_cfg.clip_top      <= 16'sh8000;
            r_cfg.clip_bottom   <= 16'sh7FFF;
            r_cfg.source_stride <= 16'h0000;
            r_cfg.dest_stride   <= 16'h0000;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X:      r_cfg.origin_x      <= $signed(i_cfg_data);
                REG_ORIGIN_Y:      r_cfg.origin_y      <= $signed(i_cfg_data);
                REG_CLIP_LEFT:     r_cfg.clip_left     <= $signed(i_cfg_data);
                REG_CLIP_RIGHT:    r_cfg.clip_right    <= $signed(i_cfg_data);
                REG_CLIP_TOP:      r_cfg.clip_top      <= $signed(i_cfg_data);
                REG_CLIP_BOTTOM:   r_cfg.clip_bottom   <= $signed(i_cfg_data);
                REG_SOURCE_STRIDE: r_cfg.source_stride <= i_cfg_data;
                REG_DEST_STRIDE:   r_cfg.dest_stride   <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    rsag_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_row_offset    (i_row_offset),
        .i_column_offset (i_column_offset),
        .i_src_start_x   (i_src_start_x),
        .i_src_start_y   (i_src_start_y),
        .i_step_x        (i_step_x),
        .i_step_y        (i_step_y),
        .i_span_length   (i_span_length),
        .o_pix           (pix)
    );

    rsag_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_source_stride (r_cfg.source_stride),
        .i_dest_stride   (r_cfg.dest_stride),
        .i_pix           (pix),
        .o_valid         (o_valid),
        .o_source_offset (o_source_offset),
        .o_dest_offset   (o_dest_offset),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

`default_nettype wire

@@ sim/tb_rotated_span_address_generator_core.sv @@
`timescale 1ns / 1ps

module tb_rotated_span_address_generator_core;
    import rsag_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int GAP_MAX        = 16;

    typedef struct {
        logic signed [15:0] row_offset;
        logic signed [15:0] column_offset;
        logic signed [15:0] src_start_x;
        logic signed [15:0] src_start_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic [LEN_W-1:0]   span_length;
    } t_span_desc;

    typedef struct {
        logic [47:0] source_offset;
        logic [47:0] dest_offset;
        logic        last_pixel;
    } t_pixel_addr;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_start         = 1'b0;
    logic                     o_busy;
    logic                     i_cfg_we        = 1'b0;
    logic [2:0]               i_cfg_index     = '0;
    logic [15:0]              i_cfg_data      = '0;
    logic signed [15:0]       i_row_offset    = '0;
    logic signed [15:0]       i_column_offset = '0;
    logic signed [15:0]       i_src_start_x   = '0;
    logic signed [15:0]       i_src_start_y   = '0;
    logic signed [31:0]       i_step_x        = '0;
    logic signed [31:0]       i_step_y        = '0;
    logic [LEN_W-1:0]         i_span_length   = '0;
    logic                     o_valid;
    logic signed [47:0]       o_source_offset;
    logic signed [47:0]       o_dest_offset;
    logic                     o_last_pixel;

    logic [15:0] reg_shadow [8];
    t_pixel_addr pending_pixels [$];
    t_pixel_addr head_pixel;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          max_gap     = 0;

    rotated_span_address_generator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_row_offset    (i_row_offset),
        .i_column_offset (i_column_offset),
        .i_src_start_x   (i_src_start_x),
        .i_src_start_y   (i_src_start_y),
        .i_step_x        (i_step_x),
        .i_step_y        (i_step_y),
        .i_span_length   (i_span_length),
        .o_valid         (o_valid),
        .o_source_offset (o_source_offset),
        .o_dest_offset   (o_dest_offset),
        .o_last_pixel    (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_span_pixels(t_span_desc d);
        longint ox, oy, cl, cr, ct, cb, sstride, dstride;
        longint y, x, len, first, stop, i, sx, sy, so, doff;
        t_pixel_addr p;
        ox      = $signed(reg_shadow[REG_ORIGIN_X]);
        oy      = $signed(reg_shadow[REG_ORIGIN_Y]);
        cl      = $signed(reg_shadow[REG_CLIP_LEFT]);
        cr      = $signed(reg_shadow[REG_CLIP_RIGHT]);
        ct      = $signed(reg_shadow[REG_CLIP_TOP]);
        cb      = $signed(reg_shadow[REG_CLIP_BOTTOM]);
        sstride = reg_shadow[REG_SOURCE_STRIDE];
        dstride = reg_shadow[REG_DEST_STRIDE];
        y       = oy + d.row_offset;
        x       = ox + d.column_offset;
        len     = d.span_length;
        if (y < ct || y > cb) begin
            return;
        end
        if (len > MAX_SPAN) begin
            len = MAX_SPAN;
        end
        first = (x < cl) ? cl - x : 0;
        stop  = (x + len - 1 > cr) ? cr - x + 1 : len;
        for (i = first; i < stop; i++) begin
            sx   = d.src_start_x + ((longint'(d.step_x) * i) >>> 16);
            sy   = d.src_start_y + ((longint'(d.step_y) * i) >>> 16);
            so   = sy * sstride + sx * PIXEL_BYTES;
            doff = y * dstride + (x + i) * PIXEL_BYTES;
            p.source_offset = so[47:0];
            p.dest_offset   = doff[47:0];
            p.last_pixel    = (i == stop - 1);
            pending_pixels.push_back(p);
        end
    endfunction

    function automatic t_span_desc make_span(int row, int col, int sx, int sy,
                                             logic [31:0] stx, logic [31:0] sty, int len);
        t_span_desc d;
        d.row_offset    = 16'(row);
        d.column_offset = 16'(col);
        d.src_start_x   = 16'(sx);
        d.src_start_y   = 16'(sy);
        d.step_x        = stx;
        d.step_y        = sty;
        d.span_length   = LEN_W'(len);
        return d;
    endfunction

    function automatic logic [31:0] random_step();
        if ($urandom_range(0, 1) == 0) begin
            return 32'($urandom_range(0, 262143) - 131072);
        end
        return $urandom;
    endfunction

    // Most descriptors are aimed at the clip window so that they tend to survive clipping.
    function automatic t_span_desc random_span(bit aimed);
        t_span_desc d;
        int ox, oy, cl, cr, ct, cb, ty, tx, h, w;
        ox = $signed(reg_shadow[REG_ORIGIN_X]);
        oy = $signed(reg_shadow[REG_ORIGIN_Y]);
        cl = $signed(reg_shadow[REG_CLIP_LEFT]);
        cr = $signed(reg_shadow[REG_CLIP_RIGHT]);
        ct = $signed(reg_shadow[REG_CLIP_TOP]);
        cb = $signed(reg_shadow[REG_CLIP_BOTTOM]);
        if (aimed) begin
            h  = (cb >= ct && cb - ct < 1000) ? cb - ct + 4 : 4;
            w  = (cr >= cl && cr - cl < 1000) ? cr - cl + 80 : 80;
            ty = ct - 2 + $urandom_range(0, h);
            tx = cl - 70 + $urandom_range(0, w);
            d.row_offset    = 16'(ty - oy);
            d.column_offset = 16'(tx - ox);
        end else begin
            d.row_offset    = 16'($urandom);
            d.column_offset = 16'($urandom);
        end
        d.src_start_x = 16'($urandom);
        d.src_start_y = 16'($urandom);
        d.step_x      = random_step();
        d.step_y      = random_step();
        case ($urandom_range(0, 7))
            0: d.span_length = LEN_W'($urandom_range(65, 127));
            1: d.span_length = '0;
            default: d.span_length = LEN_W'($urandom_range(1, 64));
        endcase
        return d;
    endfunction

    function automatic int next_gap();
        if (max_gap == 0 || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, max_gap);
    endfunction

    task automatic send_span(t_span_desc d);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_row_offset    <= d.row_offset;
        i_column_offset <= d.column_offset;
        i_src_start_x   <= d.src_start_x;
        i_src_start_y   <= d.src_start_y;
        i_step_x        <= d.step_x;
        i_step_y        <= d.step_y;
        i_span_length   <= d.span_length;
        do @(posedge i_clk); while (o_busy);
        predict_span_pixels(d);
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        reg_shadow[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_window(int ox, int oy, int cl, int cr, int ct, int cb,
                                  int sstride, int dstride);
        write_register(REG_ORIGIN_X, 16'(ox));
        write_register(REG_ORIGIN_Y, 16'(oy));
        write_register(REG_CLIP_LEFT, 16'(cl));
        write_register(REG_CLIP_RIGHT, 16'(cr));
        write_register(REG_CLIP_TOP, 16'(ct));
        write_register(REG_CLIP_BOTTOM, 16'(cb));
        write_register(REG_SOURCE_STRIDE, 16'(sstride));
        write_register(REG_DEST_STRIDE, 16'(dstride));
    endtask

    task automatic test_unclipped_reset();
        max_gap = 0;
        send_span(make_span(0, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 4));
        send_span(make_span(32767, -32768, 32767, -32768, 32'h7FFF_FFFF, 32'h8000_0000, 64));
        send_span(make_span(-32768, 32767, -32768, 32767, 32'h8000_0000, 32'h7FFF_FFFF, 127));
        send_span(make_span(5, 10, 3, 4, 32'h0001_0000, 32'h0001_0000, 0));
        send_span(make_span(-7, 100, -20, 33, 32'hFFFF_8000, 32'h0001_8000, 10));
        send_span(make_span(1, -200, 500, -500, 32'hFFFF_FFFF, 32'h0000_0001, 64));
        wait_idle();
    endtask

    task automatic test_clip_edges();
        max_gap = GAP_MAX;
        program_window(100, 50, 90, 130, 40, 60, 320, 640);
        send_span(make_span(-10, -20, 10, 20, 32'h0000_C000, 32'hFFFF_4000, 20));
        send_span(make_span(10, 20, -5, 7, 32'h0002_0000, 32'h0000_0000, 20));
        send_span(make_span(-11, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 10));
        send_span(make_span(11, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 10));
        send_span(make_span(0, -30, 40, 40, 32'hFFFE_8000, 32'h0000_4000, 64));
        send_span(make_span(0, 31, 1, 1, 32'h0001_0000, 32'h0001_0000, 5));
        send_span(make_span(0, -20, 1, 1, 32'h0001_0000, 32'h0001_0000, 10));
        send_span(make_span(5, -10, 9, 9, 32'h0003_0000, 32'hFFFD_0000, 1));
        send_span(make_span(0, 0, 12, -12, 32'h0000_8000, 32'h0000_8000, 127));
        wait_idle();
    endtask

    task automatic test_inverted_clip();
        max_gap = GAP_MAX;
        program_window(0, 0, 10, 9, -100, 100, 64, 128);
        send_span(make_span(0, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 64));
        send_span(make_span(3, 5, 2, 2, 32'h0001_0000, 32'h0001_0000, 20));
        wait_idle();
        program_window(0, 0, -100, 100, 5, 4, 64, 128);
        send_span(make_span(4, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 64));
        send_span(make_span(5, 0, 0, 0, 32'h0001_0000, 32'h0000_0000, 64));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        max_gap = GAP_MAX;
        program_window(32767, -32768, -32768, 32767, -32768, 32767, 65535, 65535);
        repeat (8) send_span(random_span($urandom_range(0, 3) != 0));
        wait_idle();
        program_window(-32768, 32767, -32768, 32767, -32768, 32767, 0, 65535);
        repeat (8) send_span(random_span($urandom_range(0, 3) != 0));
        wait_idle();
    endtask

    task automatic test_random_windows();
        logic signed [15:0] cx, cy;
        for (int phase = 0; phase < 6; phase++) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            max_gap = (phase % 2 == 0) ? GAP_MAX : 0;
            program_window($signed(16'($urandom)), $signed(16'($urandom)),
                           cx - $urandom_range(0, 80), cx + $urandom_range(0, 80),
                           cy - $urandom_range(0, 10), cy + $urandom_range(0, 10),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            repeat (16) send_span(random_span($urandom_range(0, 4) != 0));
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result beat: source_offset %h dest_offset %h",
                       o_source_offset, o_dest_offset);
                error_count++;
            end else begin
                head_pixel = pending_pixels.pop_front();
                if (o_source_offset !== head_pixel.source_offset) begin
                    $error("source_offset: expected %h, got %h",
                           head_pixel.source_offset, o_source_offset);
                    error_count++;
                end
                if (o_dest_offset !== head_pixel.dest_offset) begin
                    $error("dest_offset: expected %h, got %h",
                           head_pixel.dest_offset, o_dest_offset);
                    error_count++;
                end
                if (o_last_pixel !== head_pixel.last_pixel) begin
                    $error("last_pixel: expected %b, got %b",
                           head_pixel.last_pixel, o_last_pixel);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rotated_span_address_generator_core: FAIL");
            $finish;
        end
    end

    initial begin
        reg_shadow[REG_ORIGIN_X]      = 16'h0000;
        reg_shadow[REG_ORIGIN_Y]      = 16'h0000;
        reg_shadow[REG_CLIP_LEFT]     = 16'h8000;
        reg_shadow[REG_CLIP_RIGHT]    = 16'h7FFF;
        reg_shadow[REG_CLIP_TOP]      = 16'h8000;
        reg_shadow[REG_CLIP_BOTTOM]   = 16'h7FFF;
        reg_shadow[REG_SOURCE_STRIDE] = 16'h0000;
        reg_shadow[REG_DEST_STRIDE]   = 16'h0000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_unclipped_reset();
        test_clip_edges();
        test_inverted_clip();
        test_register_extremes();
        test_random_windows();
        if (error_count == 0) begin
            $display("tb_rotated_span_address_generator_core: PASS");
        end else begin
            $display("tb_rotated_span_address_generator_core: FAIL");
        end
        $finish;
    end

endmodule
